// ----- rtl/nqb_pkg.sv -----
// Shared types and constants for the N-queens backtracking solver.
package nqb_pkg;

    localparam int MAX_N_DEFAULT = 16;
    localparam int SIZE_W        = 5;
    localparam int IDX_W         = 4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_POP,
        ST_EMIT_RD,
        ST_EMIT_WR,
        ST_FAIL
    } nqb_state_t;

    typedef struct packed {
        logic clear;
        logic place;
        logic remove;
    } nqb_mask_op_t;

endpackage

// ----- rtl/n_queens_backtrack_solver.sv -----
// Top level of the N-queens solver: search sequencer, row stack and result register.
//
// A transaction on the input channel (in_valid/in_ready) carries one board size N.
// The block then searches for the first placement of N non-attacking queens,
// filling columns left to right and trying rows from zero upward.
// Each search node that places a queen is handled in ST_SEARCH; each step
// back also passes through ST_POP, because the row of the previous column
// comes out of the row stack memory in the cycle after its read. Rows are
// checked against row and diagonal occupancy masks, so node cost does not
// grow with the column. On success the block sends N result transactions,
// one per column in order, with found set and last_result on column N-1;
// each is a stack read in ST_EMIT_RD and then a load of the result register
// in ST_EMIT_WR. With no solution, or with N of zero or above MAX_N, a single
// result with found clear follows; both for a bad N and after column 0 runs
// out of rows, ST_FAIL loads it once the result register is free.
// in_ready is high only between searches. The result register decouples the
// output: a new board size is taken while the final result still waits, and
// the sequencer waits to load a result while the receiver holds out_ready low.
// Reset clears the control state and masks; the stack needs no clearing,
// since every entry is written before it is read.
module n_queens_backtrack_solver
    import nqb_pkg::*;
#(
    parameter int MAX_N = MAX_N_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [SIZE_W-1:0] board_size,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [IDX_W-1:0]  column_index,
    output logic [IDX_W-1:0]  queen_row,
    output logic              found,
    output logic              last_result
);

    localparam int ROW_W = $clog2(MAX_N);
    localparam int CNT_W = $clog2(MAX_N + 1);

    nqb_state_t state_reg, state_next;

    logic [CNT_W-1:0] n_reg, n_next;
    logic [CNT_W-1:0] col_reg, col_next;
    logic [CNT_W-1:0] start_reg, start_next;
    logic [CNT_W-1:0] col_m1;

    logic             out_valid_reg, out_valid_next;
    logic [IDX_W-1:0] column_index_reg, column_index_next;
    logic [IDX_W-1:0] queen_row_reg, queen_row_next;
    logic             found_reg, found_next;
    logic             last_reg, last_next;

    logic             in_fire;
    logic             out_free;
    logic             size_bad;
    logic             col_done;
    logic             is_last;

    nqb_mask_op_t     mask_op;
    logic [ROW_W-1:0] op_row, op_col;
    logic             hit;
    logic [ROW_W-1:0] hit_row;

    logic             mem_we, mem_re;
    logic [ROW_W-1:0] mem_raddr;
    logic [ROW_W-1:0] rdata;

    logic [CNT_W+IDX_W-1:0] col_ext;
    logic [ROW_W+IDX_W-1:0] row_ext;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign size_bad = (board_size == '0)
                      || ({1'b0, board_size} > (SIZE_W + 1)'(MAX_N));
    assign col_done = (col_reg == n_reg);
    assign col_m1   = col_reg - CNT_W'(1);
    assign is_last  = ((col_reg + CNT_W'(1)) == n_reg);
    assign col_ext  = {{IDX_W{1'b0}}, col_reg};
    assign row_ext  = {{IDX_W{1'b0}}, rdata};

    nqb_stack_mem #(
        .DEPTH (MAX_N),
        .AW    (ROW_W),
        .DW    (ROW_W)
    ) u_stack (
        .clk   (clk),
        .we    (mem_we),
        .waddr (col_reg[ROW_W-1:0]),
        .wdata (hit_row),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (rdata)
    );

    nqb_conflict #(
        .MAX_N (MAX_N),
        .ROW_W (ROW_W),
        .CNT_W (CNT_W)
    ) u_conflict (
        .clk    (clk),
        .rst_n  (rst_n),
        .op     (mask_op),
        .op_row (op_row),
        .op_col (op_col),
        .col    (col_reg[ROW_W-1:0]),
        .start  (start_reg),
        .n      (n_reg),
        .hit    (hit),
        .row    (hit_row)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = size_bad ? ST_FAIL : ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (col_done)
                begin
                    state_next = ST_EMIT_RD;
                end
                else if (!hit)
                begin
                    state_next = (col_reg == '0) ? ST_FAIL : ST_POP;
                end
            end
            ST_POP:
            begin
                state_next = ST_SEARCH;
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_WR;
            end
            ST_EMIT_WR:
            begin
                if (out_free)
                begin
                    state_next = is_last ? ST_IDLE : ST_EMIT_RD;
                end
            end
            ST_FAIL:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        n_next            = n_reg;
        col_next          = col_reg;
        start_next        = start_reg;
        mask_op           = '0;
        op_row            = hit_row;
        op_col            = col_reg[ROW_W-1:0];
        mem_we            = 1'b0;
        mem_re            = 1'b0;
        mem_raddr         = col_reg[ROW_W-1:0];
        out_valid_next    = out_valid_reg && !out_ready;
        column_index_next = column_index_reg;
        queen_row_next    = queen_row_reg;
        found_next        = found_reg;
        last_next         = last_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    n_next        = CNT_W'(board_size);
                    col_next      = '0;
                    start_next    = '0;
                    mask_op.clear = 1'b1;
                end
            end
            ST_SEARCH:
            begin
                if (col_done)
                begin
                    col_next = '0;
                end
                else if (hit)
                begin
                    mem_we        = 1'b1;
                    mask_op.place = 1'b1;
                    col_next      = col_reg + CNT_W'(1);
                    start_next    = '0;
                end
                else if (col_reg != '0)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = col_m1[ROW_W-1:0];
                end
            end
            ST_POP:
            begin
                // Lift the queen of the previous column and resume one row below it.
                mask_op.remove = 1'b1;
                op_row         = rdata;
                op_col         = col_m1[ROW_W-1:0];
                col_next       = col_m1;
                start_next     = CNT_W'(rdata) + CNT_W'(1);
            end
            ST_EMIT_RD:
            begin
                mem_re = 1'b1;
            end
            ST_EMIT_WR:
            begin
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    column_index_next = col_ext[IDX_W-1:0];
                    queen_row_next    = row_ext[IDX_W-1:0];
                    found_next        = 1'b1;
                    last_next         = is_last;
                    col_next          = col_reg + CNT_W'(1);
                end
            end
            ST_FAIL:
            begin
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    column_index_next = '0;
                    queen_row_next    = '0;
                    found_next        = 1'b0;
                    last_next         = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            n_reg         <= '0;
            col_reg       <= '0;
            start_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            col_reg       <= col_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        column_index_reg <= column_index_next;
        queen_row_reg    <= queen_row_next;
        found_reg        <= found_next;
        last_reg         <= last_next;
    end

    assign out_valid    = out_valid_reg;
    assign column_index = column_index_reg;
    assign queen_row    = queen_row_reg;
    assign found        = found_reg;
    assign last_result  = last_reg;

endmodule

// ----- rtl/nqb_stack_mem.sv -----
// Row stack of the search: one synchronous memory with a registered read port.
module nqb_stack_mem
    import nqb_pkg::*;
#(
    parameter int DEPTH = MAX_N_DEFAULT,
    parameter int AW    = $clog2(DEPTH),
    parameter int DW    = $clog2(DEPTH)
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/nqb_conflict.sv -----
// Occupancy masks for rows and both diagonals, and the first-free-row finder.
module nqb_conflict
    import nqb_pkg::*;
#(
    parameter int MAX_N = MAX_N_DEFAULT,
    parameter int ROW_W = $clog2(MAX_N),
    parameter int CNT_W = $clog2(MAX_N + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  nqb_mask_op_t     op,
    input  logic [ROW_W-1:0] op_row,
    input  logic [ROW_W-1:0] op_col,
    input  logic [ROW_W-1:0] col,
    input  logic [CNT_W-1:0] start,
    input  logic [CNT_W-1:0] n,
    output logic             hit,
    output logic [ROW_W-1:0] row
);

    localparam int D_W = 2 * MAX_N - 1;
    localparam logic [ROW_W-1:0] LAST_IDX = ROW_W'(MAX_N - 1);

    logic [MAX_N-1:0] row_mask_reg, row_mask_next;
    logic [D_W-1:0]   d1_reg, d1_next;
    logic [D_W-1:0]   d2_reg, d2_next;
    logic [MAX_N-1:0] op_oh;
    logic [D_W-1:0]   d1_oh, d2_oh;
    logic [D_W-1:0]   d1_sh, d2_sh;
    logic [MAX_N-1:0] free;

    // The anti-diagonal of (r, c) is r - c + MAX_N - 1, kept non-negative.
    assign op_oh = MAX_N'(1) << op_row;
    assign d1_oh = D_W'(op_oh) << op_col;
    assign d2_oh = D_W'(op_oh) << (LAST_IDX - op_col);

    always_comb
    begin
        row_mask_next = row_mask_reg;
        d1_next       = d1_reg;
        d2_next       = d2_reg;
        if (op.clear)
        begin
            row_mask_next = '0;
            d1_next       = '0;
            d2_next       = '0;
        end
        else if (op.place)
        begin
            row_mask_next = row_mask_reg | op_oh;
            d1_next       = d1_reg | d1_oh;
            d2_next       = d2_reg | d2_oh;
        end
        else if (op.remove)
        begin
            row_mask_next = row_mask_reg & ~op_oh;
            d1_next       = d1_reg & ~d1_oh;
            d2_next       = d2_reg & ~d2_oh;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_mask_reg <= '0;
            d1_reg       <= '0;
            d2_reg       <= '0;
        end
        else
        begin
            row_mask_reg <= row_mask_next;
            d1_reg       <= d1_next;
            d2_reg       <= d2_next;
        end
    end

    assign d1_sh = d1_reg >> col;
    assign d2_sh = d2_reg >> (LAST_IDX - col);

    always_comb
    begin
        for (int r = 0; r < MAX_N; r++)
        begin
            free[r] = !row_mask_reg[r] && !d1_sh[r] && !d2_sh[r]
                      && (CNT_W'(r) >= start) && (CNT_W'(r) < n);
        end
    end

    always_comb
    begin
        row = '0;
        for (int r = MAX_N - 1; r >= 0; r--)
        begin
            if (free[r])
            begin
                row = ROW_W'(r);
            end
        end
    end

    assign hit = |free;

endmodule

// ----- rtl/nqb_checker.sv -----
// Port-level checks of the N-queens solver, bound to the top level.
module nqb_checker
    import nqb_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic [SIZE_W-1:0] board_size,
    input logic              out_valid,
    input logic              out_ready,
    input logic [IDX_W-1:0]  column_index,
    input logic [IDX_W-1:0]  queen_row,
    input logic              found,
    input logic              last_result
);

    // A pending result must stay presented until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(column_index)
            && $stable(queen_row) && $stable(found) && $stable(last_result))
        else $error("result changed or dropped while stalled");

    // A result with found clear is the last one and carries column 0 and row 0.
    a_fail_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> last_result && column_index == '0 && queen_row == '0)
        else $error("no-solution result is malformed");

    // An input transaction makes the solver drop in_ready.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while a search starts");

    // While a solution is still being reported no new board size is taken.
    a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found && !last_result |-> !in_ready)
        else $error("input ready in the middle of a solution");

    // Columns of a solution follow one another in order.
    a_col_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && found && !last_result
            |=> !out_valid || column_index == $past(column_index) + 4'd1)
        else $error("column order broken");

endmodule

bind n_queens_backtrack_solver nqb_checker u_nqb_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .board_size   (board_size),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .column_index (column_index),
    .queen_row    (queen_row),
    .found        (found),
    .last_result  (last_result)
);

// ----- tb/sv/n_queens_backtrack_solver_tb.sv -----
// Self-checking testbench for the N-queens backtracking solver.
module n_queens_backtrack_solver_tb
    import nqb_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BOARD_MAX     = MAX_N_DEFAULT;
    localparam int DRAIN_CYCLES  = 12;
    localparam int RANDOM_BOARDS = 80;
    localparam int N_DIRECTED    = 20;

    typedef struct packed {
        logic [IDX_W-1:0] col;
        logic [IDX_W-1:0] row;
        logic             fnd;
        logic             last;
    } placement_t;

    // A typed row carries a single expected transaction: column 0, row 0, last set.
    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic              typed;
        logic              exp_found;
    } board_row_t;

    localparam board_row_t DIRECTED [N_DIRECTED] = '{
        '{5'd0,  1'b1, 1'b0},
        '{5'd1,  1'b1, 1'b1},
        '{5'd2,  1'b1, 1'b0},
        '{5'd3,  1'b1, 1'b0},
        '{5'd4,  1'b0, 1'b0},
        '{5'd5,  1'b0, 1'b0},
        '{5'd6,  1'b0, 1'b0},
        '{5'd7,  1'b0, 1'b0},
        '{5'd8,  1'b0, 1'b0},
        '{5'd31, 1'b1, 1'b0},
        '{5'd17, 1'b1, 1'b0},
        '{5'd16, 1'b0, 1'b0},
        '{5'd10, 1'b0, 1'b0},
        '{5'd21, 1'b1, 1'b0},
        '{5'd14, 1'b0, 1'b0},
        '{5'd15, 1'b0, 1'b0},
        '{5'd9,  1'b0, 1'b0},
        '{5'd11, 1'b0, 1'b0},
        '{5'd12, 1'b0, 1'b0},
        '{5'd13, 1'b0, 1'b0}
    };

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [SIZE_W-1:0] board_size = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [IDX_W-1:0]  column_index;
    logic [IDX_W-1:0]  queen_row;
    logic              found;
    logic              last_result;

    placement_t pending_placements[$];
    placement_t head;
    bit         quiet;
    int         errors;
    int         boards_sent;
    int         boards_solved;
    int         boards_empty;
    int         placements_checked;

    n_queens_backtrack_solver DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .board_size   (board_size),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .column_index (column_index),
        .queen_row    (queen_row),
        .found        (found),
        .last_result  (last_result)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Depth-first search over a per-column row stack; returns 1 with the rows filled in
    // when a full placement exists.
    function automatic bit place_queens(input int n, output int rows [BOARD_MAX]);
        int  col;
        int  r;
        int  start;
        int  i;
        int  diff;
        bit  safe;
        for (i = 0; i < BOARD_MAX; i++)
            rows[i] = 0;
        if (n == 0 || n > BOARD_MAX)
            return 1'b0;
        col = 0;
        start = 0;
        while (col < n)
        begin
            for (r = start; r < n; r++)
            begin
                safe = 1'b1;
                for (i = 0; i < col; i++)
                begin
                    diff = (rows[i] > r) ? rows[i] - r : r - rows[i];
                    if (rows[i] == r || diff == col - i)
                        safe = 1'b0;
                end
                if (safe)
                    break;
            end
            if (r < n)
            begin
                rows[col] = r;
                col++;
                start = 0;
            end
            else
            begin
                if (col == 0)
                    return 1'b0;
                col--;
                start = rows[col] + 1;
            end
        end
        return 1'b1;
    endfunction

    task automatic queue_placements(input logic [SIZE_W-1:0] size);
        int         rows [BOARD_MAX];
        placement_t p;
        if (place_queens(int'(size), rows))
        begin
            boards_solved++;
            for (int k = 0; k < int'(size); k++)
            begin
                p.col  = IDX_W'(k);
                p.row  = IDX_W'(rows[k]);
                p.fnd  = 1'b1;
                p.last = (k == int'(size) - 1);
                pending_placements.push_back(p);
            end
        end
        else
        begin
            boards_empty++;
            pending_placements.push_back('{col: '0, row: '0, fnd: 1'b0, last: 1'b1});
        end
    endtask

    // Sends one board size; gaps before the transaction are drawn per item.
    task automatic send_board(input logic [SIZE_W-1:0] size, input bit typed,
                              input bit exp_found);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        board_size <= size;
        do
            @(posedge clk);
        while (!in_ready);
        boards_sent++;
        if (typed)
        begin
            if (exp_found)
                boards_solved++;
            else
                boards_empty++;
            pending_placements.push_back('{col: '0, row: '0, fnd: exp_found, last: 1'b1});
        end
        else
            queue_placements(size);
    endtask

    task automatic wait_all_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_placements.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [SIZE_W-1:0] random_board();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 3)
            return '0;
        if (sel < 10)
            return SIZE_W'($urandom_range(BOARD_MAX + 1, 31));
        // Large boards take long searches, so they stay rare.
        if (sel < 18)
            return SIZE_W'($urandom_range(13, BOARD_MAX));
        return SIZE_W'($urandom_range(1, 12));
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // Result receiver: after each accepted transaction, ready may drop for a drawn stall.
    initial
    begin : receiver
        int stall;
        @(posedge rst_n);
        @(posedge clk);
        out_ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                stall = quiet ? 0 : $urandom_range(0, 9);
                if (stall > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                    out_ready <= 1'b1;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_placements.size() == 0)
            begin
                $display("%0t: unexpected result, actual col=%0d row=%0d found=%0b last=%0b",
                         $time, column_index, queen_row, found, last_result);
                errors++;
            end
            else
            begin
                head = pending_placements.pop_front();
                placements_checked++;
                check_field("column_index", int'(head.col), int'(column_index));
                check_field("queen_row", int'(head.row), int'(queen_row));
                check_field("found", int'(head.fnd), int'(found));
                check_field("last_result", int'(head.last), int'(last_result));
            end
        end
    end

    initial
    begin
        quiet = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++)
            send_board(DIRECTED[i].size, DIRECTED[i].typed, DIRECTED[i].exp_found);
        wait_all_results();

        for (int i = 0; i < RANDOM_BOARDS; i++)
        begin
            if (i % 10 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            // Now and then hold off until the solver has handed back every result.
            if (i % 25 == 24)
                wait_all_results();
            send_board(random_board(), 1'b0, 1'b0);
        end

        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d board sizes: %0d solved, %0d with no placement.",
                 boards_sent, boards_solved, boards_empty);
        $display("Checked %0d result transactions field by field.", placements_checked);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #100ms;
        $display("%0t: timeout with %0d results outstanding", $time, pending_placements.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
